[hdl/partition_fit_allocator_assert.svh]
`ifndef PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfa assertion failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfa assertion failed");

`endif

[hdl/pfa_pkg.sv]
package pfa_pkg;

  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int OPCODE_W       = 1;
  localparam int BLOCK_INDEX_W  = 3;
  localparam int SIZE_VALUE_W   = 16;
  localparam int FIT_MODE_W     = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

  localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_run;
    logic commit;
    logic out_push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic scan_end;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hdl/pfa_ctrl.sv]
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfa_pkg::ctrl_sts_t sts,
  output pfa_pkg::ctrl_cmd_t cmd
);
  import pfa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.is_load ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD:   state_next = ST_DONE;
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD:   cmd.load_wr  = 1'b1;
      ST_SCAN:   cmd.scan_run = 1'b1;
      ST_COMMIT: cmd.commit   = 1'b1;
      ST_DONE:   cmd.out_push = sts.out_free;
      default:   in_stall     = 1'b1;
    endcase
  end

endmodule

[hdl/pfa_datapath.sv]
module pfa_datapath #(
  parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pfa_pkg::FIT_MODE_W-1:0]     cfg_wr_data,
  input  logic [pfa_pkg::OPCODE_W-1:0]       opcode,
  input  logic [pfa_pkg::BLOCK_INDEX_W-1:0]  block_index,
  input  logic [pfa_pkg::SIZE_VALUE_W-1:0]   size_value,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               granted,
  output logic [pfa_pkg::BLOCK_INDEX_W-1:0]  chosen_block,
  output logic [pfa_pkg::SIZE_VALUE_W-1:0]   remaining_after,
  input  pfa_pkg::ctrl_cmd_t                 cmd,
  output pfa_pkg::ctrl_sts_t                 sts
);
  import pfa_pkg::*;

  localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W    = (SIZE_BITS > SIZE_VALUE_W) ? SIZE_BITS : SIZE_VALUE_W;

  logic [SIZE_BITS-1:0]     mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]    vld;

  logic [FIT_MODE_W-1:0]    fit_mode;
  logic [OPCODE_W-1:0]      req_op;
  logic [BLOCK_INDEX_W-1:0] req_idx;
  logic [SIZE_VALUE_W-1:0]  req_size;

  logic [CNT_BITS-1:0]      cnt;
  logic                     rd_live;
  logic [IDX_BITS-1:0]      rd_idx;
  logic [SIZE_BITS-1:0]     rd_data;
  logic                     rd_vld;

  logic                     found;
  logic [IDX_BITS-1:0]      sel_idx;
  logic [SIZE_BITS-1:0]     sel_val;

  logic                     res_granted;
  logic [IDX_BITS-1:0]      res_idx;
  logic [SIZE_BITS-1:0]     res_rem;

  logic                     issue;
  logic [IDX_BITS-1:0]      rd_addr;
  logic [SIZE_BITS-1:0]     entry;
  logic                     fits;
  logic                     better;
  logic                     first_mode;
  logic                     take;
  logic                     load_ok;
  logic [IDX_BITS-1:0]      load_addr;
  logic [SIZE_BITS-1:0]     load_val;
  logic [SIZE_BITS-1:0]     diff;
  logic                     wr_en;
  logic [IDX_BITS-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]     wr_data;

  assign issue   = cmd.scan_run && (cnt < CNT_BITS'(NUM_BLOCKS));
  assign rd_addr = cnt[IDX_BITS-1:0];
  assign entry   = rd_vld ? rd_data : '0;
  assign fits    = CMP_W'(entry) >= CMP_W'(req_size);

  assign first_mode = (fit_mode != FIT_BEST) && (fit_mode != FIT_WORST);

  always_comb begin
    case (fit_mode)
      FIT_BEST:  better = entry < sel_val;
      FIT_WORST: better = entry > sel_val;
      default:   better = 1'b0;
    endcase
  end

  assign take = cmd.scan_run && rd_live && fits && (!found || better);

  assign load_ok   = 32'(req_idx) < 32'(NUM_BLOCKS);
  assign load_addr = IDX_BITS'(req_idx);
  assign load_val  = SIZE_BITS'(req_size);
  assign diff      = sel_val - SIZE_BITS'(req_size);

  assign wr_en   = (cmd.load_wr && load_ok) || (cmd.commit && found);
  assign wr_addr = cmd.load_wr ? load_addr : sel_idx;
  assign wr_data = cmd.load_wr ? load_val : diff;

  assign sts.is_load  = (opcode == OP_LOAD);
  assign sts.scan_end = rd_live &&
                        ((rd_idx == IDX_BITS'(NUM_BLOCKS - 1)) || (fits && first_mode));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      fit_mode <= FIT_FIRST;
      cnt      <= '0;
      rd_live  <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fit_mode <= cfg_wr_data;
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (cmd.capture) begin
        cnt     <= '0;
        rd_live <= 1'b0;
        found   <= 1'b0;
      end else begin
        rd_live <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op   <= opcode;
      req_idx  <= block_index;
      req_size <= size_value;
    end
    if (issue) begin
      rd_idx <= rd_addr;
      rd_vld <= vld[rd_addr];
    end
    if (take) begin
      sel_idx <= rd_idx;
      sel_val <= entry;
    end
    if (cmd.load_wr || cmd.commit) begin
      if ((cmd.load_wr && load_ok) || (cmd.commit && found)) begin
        res_granted <= 1'b1;
        res_idx     <= wr_addr;
        res_rem     <= wr_data;
      end else begin
        res_granted <= 1'b0;
        res_idx     <= '0;
        res_rem     <= '0;
      end
    end
  end

  // output register, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      granted         <= res_granted && (req_op == OP_LOAD || req_op == OP_ALLOC);
      chosen_block    <= BLOCK_INDEX_W'(res_idx);
      remaining_after <= SIZE_VALUE_W'(res_rem);
    end
  end

endmodule

[hdl/partition_fit_allocator.sv]
// channel  dir  handshake             payload
// in       in   in_valid/in_stall     opcode, block_index, size_value
// out      out  out_valid/out_stall   granted, chosen_block, remaining_after
// cfg      in   cfg_wr_en             cfg_wr_data (fit_mode)
//
// load: the item passes the LOAD state, then DONE pushes it to the output register
// request: the SCAN and COMMIT states, then DONE to the output register, one
//   entry a cycle through the size table's read port, ending early on a first-fit hit
// reset clears the entry valid bits at once, all sizes read as zero, first fit
// in_stall is high from accept until the result enters the output register
// out_stall holds the result; the next item runs and waits before output
module partition_fit_allocator #(
  parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pfa_pkg::FIT_MODE_W-1:0]     cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pfa_pkg::OPCODE_W-1:0]       opcode,
  input  logic [pfa_pkg::BLOCK_INDEX_W-1:0]  block_index,
  input  logic [pfa_pkg::SIZE_VALUE_W-1:0]   size_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               granted,
  output logic [pfa_pkg::BLOCK_INDEX_W-1:0]  chosen_block,
  output logic [pfa_pkg::SIZE_VALUE_W-1:0]   remaining_after
);
  import pfa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .opcode          (opcode),
    .block_index     (block_index),
    .size_value      (size_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .granted         (granted),
    .chosen_block    (chosen_block),
    .remaining_after (remaining_after),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[hdl/pfa_checker.sv]
`include "partition_fit_allocator_assert.svh"

module pfa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_wr_en,
  input logic [pfa_pkg::FIT_MODE_W-1:0]     cfg_wr_data,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [pfa_pkg::OPCODE_W-1:0]       opcode,
  input logic [pfa_pkg::BLOCK_INDEX_W-1:0]  block_index,
  input logic [pfa_pkg::SIZE_VALUE_W-1:0]   size_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               granted,
  input logic [pfa_pkg::BLOCK_INDEX_W-1:0]  chosen_block,
  input logic [pfa_pkg::SIZE_VALUE_W-1:0]   remaining_after
);

  // stalled result holds
  `PFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(granted) && $stable(chosen_block) && $stable(remaining_after))

  // a refused item reports zero index and size
  `PFA_ASSERT_NOW(a_refuse_zero, out_valid && !granted,
    chosen_block == '0 && remaining_after == '0)

  // one item at a time: input closes right after an accept
  `PFA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // a new result only appears after an item has been taken in
  `PFA_ASSERT_NOW(a_out_after_in, $rose(out_valid), $past(in_stall))

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);
